// ===== rtl/seven_segment_scan_driver_defines.svh =====
// assertion macros for the seven-segment scan driver checker
// expects clk_i and rst_ni in the scope of every use
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ssd_pkg.sv =====
// shared types, constants and the glyph lookup for the scan driver
// no dependencies
package ssd_pkg;

  localparam int unsigned SLOTS       = 4;
  localparam int unsigned SLOT_W      = 2;
  localparam int unsigned SEG_W       = 8;
  localparam int unsigned WORD_BITS   = 16;
  localparam int unsigned BIT_CNT_W   = 4;
  localparam int unsigned HOLD_W      = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 8;

  localparam logic [HOLD_W-1:0]    HOLD_RESET = 16'd1500;
  localparam logic [SEG_W-1:0]     SELECT_ALL = 8'hFF;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT   = 4'd15;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SHOW = 1'b1;

  typedef logic [SLOTS-1:0][SEG_W-1:0] seg_row_t;

  // command passed from the front to the back
  typedef struct packed {
    logic     is_show;
    seg_row_t seg;
  } cmd_t;

  // queue read side towards the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  function automatic logic [SEG_W-1:0] glyph_for(input logic [7:0] ch, input logic dot);
    logic [SEG_W-1:0] g;
    begin
      case (ch)
        8'h30:   g = 8'hFC;
        8'h31:   g = 8'h60;
        8'h32:   g = 8'hDA;
        8'h33:   g = 8'hF2;
        8'h34:   g = 8'h66;
        8'h35:   g = 8'hB6;
        8'h36:   g = 8'hBE;
        8'h37:   g = 8'hE0;
        8'h38:   g = 8'hFE;
        8'h39:   g = 8'hF6;
        default: g = '0;
      endcase
      return g | {{(SEG_W-1){1'b0}}, dot};
    end
  endfunction

endpackage

// ===== rtl/seven_segment_scan_driver.sv =====
// top level of the four-digit seven-segment scan driver
// depends on ssd_pkg, ssd_front, ssd_queue and ssd_back
//
//  channel   | direction | moves
//  ----------+-----------+-----------------------------------------------
//  s_axis    | in        | show request (four chars + dots) or refresh tick
//  cfg       | in        | hold_ticks write, 16 bits
//  m_axis    | out       | one serial bit of the display word per request
//
// a refresh tick yields 16 output requests, one bit per cycle while the sink is
// ready; the serialiser is what sets the rate at which tick words are taken
// the next tick word loads in the cycle its predecessor's last bit leaves
// a show request is taken as soon as it heads the queue and does not disturb a running word
// reset is asynchronous and active low; no clearing pass is needed
// a two-entry queue lets input and output stall independently
module seven_segment_scan_driver #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // char_one[7:0], dot_one, char_two, dot_two, char_three, dot_three,
  // char_four, dot_four (bits 35:0), zero fill above
  input  logic [ssd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func: 0 refresh tick, 1 show
  input  logic [0:0]                      s_axis_tuser,
  // configuration write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ssd_pkg::HOLD_W-1:0]      cfg_data_i,
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // serial_data in bit 0, zero fill above
  output logic [ssd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // scan_slot
  output logic [ssd_pkg::SLOT_W-1:0]      m_axis_tuser,
  // latch_last, high on the sixteenth bit of a word
  output logic                            m_axis_tlast
);

  logic               q_full, push, pop;
  ssd_pkg::cmd_t      cmd;
  ssd_pkg::cmd_head_t head;

  // register writes are to happen only while idle, which the block itself does not enforce; ready is tied high
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;

  // front end: glyph conversion and classification
  ssd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  // decoupling queue
  ssd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // back end: hold timer, display buffers and serialiser
  ssd_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/ssd_front.sv =====
// front end: takes input requests, converts characters to segment bytes
// depends on ssd_pkg
module ssd_front (
  input  logic                           s_axis_tvalid,
  input  logic [ssd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]                     s_axis_tuser,
  input  logic                           q_full_i,
  output logic                           push_o,
  output ssd_pkg::cmd_t                  cmd_o
);

  assign push_o = s_axis_tvalid && !q_full_i;

  always_comb begin
    cmd_o.is_show = (s_axis_tuser[0] == ssd_pkg::FUNC_SHOW);
    // leftmost character sits in the lowest bits and drives slot three
    cmd_o.seg[3]  = ssd_pkg::glyph_for(s_axis_tdata[7:0],   s_axis_tdata[8]);
    cmd_o.seg[2]  = ssd_pkg::glyph_for(s_axis_tdata[16:9],  s_axis_tdata[17]);
    cmd_o.seg[1]  = ssd_pkg::glyph_for(s_axis_tdata[25:18], s_axis_tdata[26]);
    cmd_o.seg[0]  = ssd_pkg::glyph_for(s_axis_tdata[34:27], s_axis_tdata[35]);
  end

endmodule

// ===== rtl/ssd_queue.sv =====
// short command queue between front and back
// depends on ssd_pkg
module ssd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ssd_pkg::cmd_t      cmd_i,
  output logic               full_o,
  output ssd_pkg::cmd_head_t head_o,
  input  logic               pop_i
);

  localparam int unsigned PtrW = $clog2(ssd_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(ssd_pkg::QUEUE_DEPTH + 1);

  ssd_pkg::cmd_t  mem_q [ssd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(ssd_pkg::QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    begin
      return (p == PtrW'(ssd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
    end
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/ssd_back.sv =====
// back end: display state, hold timer and 16-bit serialiser
// depends on ssd_pkg
module ssd_back #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ssd_pkg::cmd_head_t               head_i,
  output logic                             pop_o,
  input  logic                             cfg_valid_i,
  input  logic [ssd_pkg::HOLD_W-1:0]       cfg_data_i,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ssd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [ssd_pkg::SLOT_W-1:0]       m_axis_tuser,
  output logic                             m_axis_tlast
);

  logic [ssd_pkg::HOLD_W-1:0]    hold_ticks_q, hold_q, hold_d, hold_dec;
  ssd_pkg::seg_row_t             shown_q, shown_d, pending_q, pending_d;
  logic                          upd_q, upd_d, apply;
  logic [ssd_pkg::SLOT_W-1:0]    scan_q, scan_d, slot_q, slot_d;
  logic [ssd_pkg::WORD_BITS-1:0] word_q, word_d;
  logic [ssd_pkg::BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          out_hs, last_hs, pop_tick, pop_show;
  logic [ssd_pkg::SEG_W-1:0]     upper;

  assign out_hs   = busy_q && m_axis_tready;
  assign last_hs  = out_hs && (cnt_q == ssd_pkg::LAST_BIT);
  assign pop_show = head_i.valid && head_i.cmd.is_show;
  assign pop_tick = head_i.valid && !head_i.cmd.is_show && (!busy_q || last_hs);
  assign pop_o    = pop_show || pop_tick;

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {{(ssd_pkg::OUT_DATA_W-1){1'b0}}, word_q[0]};
  assign m_axis_tuser  = slot_q;
  assign m_axis_tlast  = (cnt_q == ssd_pkg::LAST_BIT);

  always_comb begin
    hold_dec  = (hold_q != '0) ? hold_q - ssd_pkg::HOLD_W'(1) : hold_q;
    apply     = upd_q && (hold_dec == '0);
    upper     = ssd_pkg::SELECT_ALL ^ (ssd_pkg::SEG_W'(3) << {scan_q, 1'b0});

    hold_d    = hold_q;
    shown_d   = shown_q;
    pending_d = pending_q;
    upd_d     = upd_q;
    scan_d    = scan_q;
    slot_d    = slot_q;
    word_d    = word_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;

    if (out_hs) begin
      word_d = {1'b0, word_q[ssd_pkg::WORD_BITS-1:1]};
      cnt_d  = cnt_q + ssd_pkg::BIT_CNT_W'(1);
      if (last_hs) begin
        busy_d = 1'b0;
      end
    end

    if (pop_show) begin
      pending_d = head_i.cmd.seg;
      upd_d     = 1'b1;
    end

    if (pop_tick) begin
      hold_d = hold_dec;
      if (apply) begin
        shown_d = pending_q;
        upd_d   = 1'b0;
        hold_d  = hold_ticks_q;
      end
      word_d = {upper, shown_d[scan_q]};
      cnt_d  = '0;
      busy_d = 1'b1;
      slot_d = scan_q;
      if ((ssd_pkg::SLOT_W+1)'(scan_q) + (ssd_pkg::SLOT_W+1)'(1)
          >= (ssd_pkg::SLOT_W+1)'(DIGIT_COUNT)) begin
        scan_d = '0;
      end else begin
        scan_d = scan_q + ssd_pkg::SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= ssd_pkg::HOLD_RESET;
      hold_q       <= '0;
      shown_q      <= '0;
      pending_q    <= '0;
      upd_q        <= 1'b0;
      scan_q       <= '0;
      slot_q       <= '0;
      cnt_q        <= '0;
      busy_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        hold_ticks_q <= cfg_data_i;
      end
      hold_q    <= hold_d;
      shown_q   <= shown_d;
      pending_q <= pending_d;
      upd_q     <= upd_d;
      scan_q    <= scan_d;
      slot_q    <= slot_d;
      cnt_q     <= cnt_d;
      busy_q    <= busy_d;
    end
  end

endmodule

// ===== rtl/ssd_checker.sv =====
// port-level checker for the scan driver, bound to the top level
// depends on ssd_pkg and seven_segment_scan_driver_defines.svh
`include "seven_segment_scan_driver_defines.svh"

module ssd_checker #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ssd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [ssd_pkg::SLOT_W-1:0]      m_axis_tuser,
  input logic                            m_axis_tlast
);

  logic [ssd_pkg::SLOT_W:0] slot_ext;
  assign slot_ext = {1'b0, m_axis_tuser};

  // a word runs without gaps and on one slot until its last bit
  `SSD_ASSERT_NEXT(a_word_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
    m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser)), "word broken before last bit")

  // a stalled bit holds
  `SSD_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output changed")

  // only bit 0 of the data carries anything
  `SSD_ASSERT_SAME(a_fill_zero, m_axis_tvalid,
    m_axis_tdata[ssd_pkg::OUT_DATA_W-1:1] == '0, "data fill bits not zero")

  // slot stays inside the configured digit count
  `SSD_ASSERT_SAME(a_slot_range, m_axis_tvalid,
    slot_ext < (ssd_pkg::SLOT_W+1)'(DIGIT_COUNT), "scan slot out of range")

endmodule

bind seven_segment_scan_driver ssd_checker #(
  .DIGIT_COUNT (DIGIT_COUNT)
) u_ssd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
